FILE: rtl/nearest_point_with_exclusions_assert.svh
// ----------------------------------------------------------------------------
// nearest point with exclusions assertion macros
// concurrent checks, left out of synthesis
// ----------------------------------------------------------------------------
`ifndef NEAREST_POINT_WITH_EXCLUSIONS_ASSERT_SVH
`define NEAREST_POINT_WITH_EXCLUSIONS_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define NPWE_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("npwe assertion failed");
// next-cycle implication
`define NPWE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("npwe assertion failed");
`else
`define NPWE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define NPWE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/npwe_pkg.sv
// ----------------------------------------------------------------------------
// npwe_pkg
// shared types and constants of the nearest point search
// ----------------------------------------------------------------------------
package npwe_pkg;

  localparam int COORD_W = 16;
  localparam int SIZE_W  = 15;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 32;
  localparam int SUM_W   = SQ_W + 1;
  localparam int DIST_W  = 34;
  localparam int R2_W    = 2 * SIZE_W;

  typedef enum logic [2:0] {
    CMD_CLEAR     = 3'd0,
    CMD_ADD_BOX   = 3'd1,
    CMD_ADD_RES   = 3'd2,
    CMD_START     = 3'd3,
    CMD_CANDIDATE = 3'd4,
    CMD_FINISH    = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BOX,
    S_RES,
    S_REF,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [SIZE_W-1:0]         w;
    logic [SIZE_W-1:0]         h;
  } box_entry_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  // tag that travels with a distance through the squaring stage
  typedef struct packed {
    logic res;
    logic last;
  } npwe_tag_t;

endpackage

FILE: rtl/npwe_sq_dist.sv
// ----------------------------------------------------------------------------
// npwe_sq_dist
// registered squares of the x and y differences of two points
// ----------------------------------------------------------------------------
module npwe_sq_dist
  import npwe_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic signed [COORD_W-1:0] a_x,
  input  logic signed [COORD_W-1:0] a_y,
  input  logic signed [COORD_W-1:0] b_x,
  input  logic signed [COORD_W-1:0] b_y,
  input  npwe_tag_t                 in_tag,
  output logic [SQ_W-1:0]           sq_x,
  output logic [SQ_W-1:0]           sq_y,
  output npwe_tag_t                 out_tag
);

  logic signed [DIFF_W-1:0]   dx;
  logic signed [DIFF_W-1:0]   dy;
  logic signed [2*DIFF_W-1:0] prod_x;
  logic signed [2*DIFF_W-1:0] prod_y;

  assign dx     = DIFF_W'(a_x) - DIFF_W'(b_x);
  assign dy     = DIFF_W'(a_y) - DIFF_W'(b_y);
  assign prod_x = dx * dx;
  assign prod_y = dy * dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tag <= '0;
    end else begin
      out_tag <= in_tag;
    end
  end

  // a squared difference is below 2^32
  always_ff @(posedge clk) begin
    sq_x <= prod_x[SQ_W-1:0];
    sq_y <= prod_y[SQ_W-1:0];
  end

endmodule

FILE: rtl/nearest_point_with_exclusions.sv
// ----------------------------------------------------------------------------
// nearest_point_with_exclusions
// nearest surviving candidate to a reference, with box and point exclusion
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one command item: clear tables,
// add box, add reserved point, start search, candidate or finish. Output
// channel (out_valid / out_stall) carries one result item per finish.
// cfg_wr_en / cfg_wr_data write the reserved radius; its square is kept.
// Table, start and clear commands are taken while idle. A candidate scans
// the box memory and then the reserved memory, one entry read per cycle,
// and then the squaring stage settles against the reference: in_stall stays
// high until the reference result leaves the squaring stage, and only then
// is the next item taken. A finish loads its result into the output register
// in the cycle after it is taken.
// The output register holds a result while out_stall is high; other items
// are still taken, only another finish waits.
// Synchronous reset empties both tables, clears the search state (best
// distance all ones) and the radius. Table contents need no clearing.
// ----------------------------------------------------------------------------
`include "nearest_point_with_exclusions_assert.svh"

module nearest_point_with_exclusions
  import npwe_pkg::*;
#(
  parameter int BOX_ENTRIES      = 16,
  parameter int RESERVED_ENTRIES = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                cmd,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic [SIZE_W-1:0]         box_width,
  input  logic [SIZE_W-1:0]         box_height,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      found,
  output logic signed [COORD_W-1:0] best_x,
  output logic signed [COORD_W-1:0] best_y,
  input  logic                      cfg_wr_en,
  input  logic [SIZE_W-1:0]         cfg_wr_data
);

  localparam int BOX_CW = $clog2(BOX_ENTRIES + 1);
  localparam int BOX_AW = (BOX_ENTRIES > 1) ? $clog2(BOX_ENTRIES) : 1;
  localparam int RES_CW = $clog2(RESERVED_ENTRIES + 1);
  localparam int RES_AW = (RESERVED_ENTRIES > 1) ? $clog2(RESERVED_ENTRIES) : 1;

  state_t state;
  state_t state_next;

  logic in_acc;
  logic box_rd_en;
  logic res_rd_en;
  logic ref_issue;

  logic [BOX_CW-1:0] box_count;
  logic [RES_CW-1:0] res_count;
  logic [BOX_CW-1:0] box_idx;
  logic [RES_CW-1:0] res_idx;

  box_entry_t box_mem [BOX_ENTRIES];
  point_t     res_mem [RESERVED_ENTRIES];
  box_entry_t box_rd;
  point_t     res_rd;
  logic       box_p1;
  logic       res_p1;
  logic       ref_p1;

  logic [R2_W-1:0]           radius_sq;
  logic signed [COORD_W-1:0] ref_x;
  logic signed [COORD_W-1:0] ref_y;
  logic signed [COORD_W-1:0] cand_x;
  logic signed [COORD_W-1:0] cand_y;
  logic                      excl;
  logic [DIST_W-1:0]         near_sq;
  logic signed [COORD_W-1:0] best_px;
  logic signed [COORD_W-1:0] best_py;
  logic                      found_flag;

  logic signed [DIFF_W-1:0] cx_ext;
  logic signed [DIFF_W-1:0] cy_ext;
  logic signed [DIFF_W-1:0] bx_ext;
  logic signed [DIFF_W-1:0] by_ext;
  logic signed [DIFF_W-1:0] bx_end;
  logic signed [DIFF_W-1:0] by_end;
  logic                     box_hit;

  logic signed [COORD_W-1:0] pt_x;
  logic signed [COORD_W-1:0] pt_y;
  npwe_tag_t                 sq_in_tag;
  npwe_tag_t                 sq_tag;
  logic [SQ_W-1:0]           sq_x;
  logic [SQ_W-1:0]           sq_y;
  logic [SUM_W-1:0]          sq_sum;

  // a finish also waits while a result is held in the output register
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall && (cmd == CMD_FINISH));
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    box_rd_en  = 1'b0;
    res_rd_en  = 1'b0;
    ref_issue  = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_acc && (cmd == CMD_CANDIDATE)) state_next = S_BOX;
      end
      S_BOX: begin
        if (box_idx < box_count) box_rd_en = 1'b1;
        else state_next = S_RES;
      end
      S_RES: begin
        if (res_idx < res_count) res_rd_en = 1'b1;
        else state_next = S_REF;
      end
      S_REF: begin
        ref_issue  = 1'b1;
        state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (sq_tag.last) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // table writes happen only in idle and reads only during a scan,
  // so the same entry is never written and read in overlapping cycles
  always_ff @(posedge clk) begin
    if (in_acc && (cmd == CMD_ADD_BOX) && (box_count < BOX_CW'(BOX_ENTRIES))) begin
      box_mem[box_count[BOX_AW-1:0]] <= '{x: coord_x, y: coord_y, w: box_width, h: box_height};
    end
    if (box_rd_en) begin
      box_rd <= box_mem[box_idx[BOX_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (cmd == CMD_ADD_RES) && (res_count < RES_CW'(RESERVED_ENTRIES))) begin
      res_mem[res_count[RES_AW-1:0]] <= '{x: coord_x, y: coord_y};
    end
    if (res_rd_en) begin
      res_rd <= res_mem[res_idx[RES_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_count <= '0;
      res_count <= '0;
      box_idx   <= '0;
      res_idx   <= '0;
      box_p1    <= 1'b0;
      res_p1    <= 1'b0;
      ref_p1    <= 1'b0;
      radius_sq <= '0;
    end else begin
      box_p1 <= box_rd_en;
      res_p1 <= res_rd_en;
      ref_p1 <= ref_issue;
      if (cfg_wr_en) radius_sq <= R2_W'(cfg_wr_data) * R2_W'(cfg_wr_data);
      if (box_rd_en) box_idx <= box_idx + BOX_CW'(1);
      if (res_rd_en) res_idx <= res_idx + RES_CW'(1);
      if (in_acc) begin
        case (cmd)
          CMD_CLEAR: begin
            box_count <= '0;
            res_count <= '0;
          end
          CMD_ADD_BOX: begin
            if (box_count < BOX_CW'(BOX_ENTRIES)) box_count <= box_count + BOX_CW'(1);
          end
          CMD_ADD_RES: begin
            if (res_count < RES_CW'(RESERVED_ENTRIES)) res_count <= res_count + RES_CW'(1);
          end
          CMD_CANDIDATE: begin
            box_idx <= '0;
            res_idx <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // half-open box test on 17-bit values, the far edge cannot overflow
  assign cx_ext  = DIFF_W'(cand_x);
  assign cy_ext  = DIFF_W'(cand_y);
  assign bx_ext  = DIFF_W'(box_rd.x);
  assign by_ext  = DIFF_W'(box_rd.y);
  assign bx_end  = bx_ext + $signed({2'b00, box_rd.w});
  assign by_end  = by_ext + $signed({2'b00, box_rd.h});
  assign box_hit = (cx_ext >= bx_ext) && (cx_ext < bx_end)
                && (cy_ext >= by_ext) && (cy_ext < by_end);

  // the reference rides the squaring stage as one last entry
  assign pt_x      = ref_p1 ? ref_x : res_rd.x;
  assign pt_y      = ref_p1 ? ref_y : res_rd.y;
  assign sq_in_tag = '{res: res_p1, last: ref_p1};

  npwe_sq_dist u_sq_dist (
    .clk     (clk),
    .rst     (rst),
    .a_x     (cand_x),
    .a_y     (cand_y),
    .b_x     (pt_x),
    .b_y     (pt_y),
    .in_tag  (sq_in_tag),
    .sq_x    (sq_x),
    .sq_y    (sq_y),
    .out_tag (sq_tag)
  );

  assign sq_sum = {1'b0, sq_x} + {1'b0, sq_y};

  always_ff @(posedge clk) begin
    if (in_acc && (cmd == CMD_CANDIDATE)) begin
      cand_x <= coord_x;
      cand_y <= coord_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      excl       <= 1'b0;
      ref_x      <= '0;
      ref_y      <= '0;
      near_sq    <= '1;
      best_px    <= '0;
      best_py    <= '0;
      found_flag <= 1'b0;
    end else begin
      if (in_acc && (cmd == CMD_CANDIDATE)) excl <= 1'b0;
      if (box_p1 && box_hit) excl <= 1'b1;
      if (sq_tag.res && (sq_sum <= SUM_W'(radius_sq))) excl <= 1'b1;
      if (sq_tag.last && !excl && (DIST_W'(sq_sum) < near_sq)) begin
        near_sq    <= DIST_W'(sq_sum);
        best_px    <= cand_x;
        best_py    <= cand_y;
        found_flag <= 1'b1;
      end
      if (in_acc && (cmd == CMD_START)) begin
        ref_x      <= coord_x;
        ref_y      <= coord_y;
        near_sq    <= '1;
        best_px    <= '0;
        best_py    <= '0;
        found_flag <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc && (cmd == CMD_FINISH)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (cmd == CMD_FINISH)) begin
      found  <= found_flag;
      best_x <= found_flag ? best_px : '0;
      best_y <= found_flag ? best_py : '0;
    end
  end

  `NPWE_ASSERT_NEXT(a_cand_scans, clk, rst, in_acc && (cmd == CMD_CANDIDATE), state == S_BOX)
  `NPWE_ASSERT_NEXT(a_finish_result, clk, rst, in_acc && (cmd == CMD_FINISH), out_valid && (found == $past(found_flag)))
  `NPWE_ASSERT_NEXT(a_ref_ends_scan, clk, rst, sq_tag.last, state == S_IDLE)
  `NPWE_ASSERT_IMPL(a_counts_bounded, clk, rst, 1'b1, (box_count <= BOX_CW'(BOX_ENTRIES)) && (res_count <= RES_CW'(RESERVED_ENTRIES)))

endmodule

FILE: sim/nearest_point_with_exclusions_tb.sv
// ----------------------------------------------------------------------------
// nearest_point_with_exclusions_tb
// drives table, search and candidate items into the nearest point search,
// predicts each finish result in-line and checks it field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module nearest_point_with_exclusions_tb
  import npwe_pkg::*;
();

  localparam int BOX_DEPTH    = 16;
  localparam int RSV_DEPTH    = 16;
  localparam int DRAIN_CYCLES = 48;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 400;

  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } nearest_result_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [14:0]        bw;
    logic [14:0]        bh;
    logic               typed;
    logic               t_hit;
    logic signed [15:0] t_x;
    logic signed [15:0] t_y;
  } directed_row_t;

  localparam int NUM_DIRECTED = 23;
  localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
    '{CMD_FINISH,    16'sd0,     16'sd0,     15'd0,     15'd0,     1'b1, 1'b0, 16'sd0, 16'sd0},
    '{CMD_CANDIDATE, 16'sd16,    16'sd32,    15'd0,     15'd0,     1'b0, 1'b0, 16'sd0, 16'sd0},
    '{CMD_FINISH,    16'sd0,     16'sd0,     15'd0,     15'd0,     1'b1, 1'b1, 16'sd16, 16'sd32},
    '{CMD_START,     16'sd0,     16'sd0,     15'd0,     15'd0,     1'b0, 1'b0, 16'sd0, 16'sd0},
    '{CMD_ADD_BOX,   16'sh8000,  16'sh8000,  15'h7fff,  15'h7fff,  1'b0, 1'b0, 16'sd0, 16'sd0},
    '{CMD_ADD_BOX,   16'sd100,   16'sd100,   15'd0,     15'd0,     1'b0, 1'b0, 16'sd0, 16'sd0},
    '{CMD_ADD_RES,   16'sd100,   16'sd100,   15'h7fff,  15'h7fff,  1'b0, 1'b0, 16'sd0, 16'sd0},
    '{CMD_CANDIDATE, 16'shfffe,  16'shfffe,  15'd0,     15'd0,     1'b0, 1'b0, 16'sd0, 16'sd0},
    '{CMD_CANDIDATE, 16'sd100,   16'sd100,   15'd0,     15'd0,     1'b0, 1'b0, 16'sd0, 16'sd0},
    '{CMD_CANDIDATE, 16'sd101,   16'sd100,   15'd0,     15'd0,     1'b0, 1'b0, 16'sd0, 16'sd0},
    '{CMD_CANDIDATE, 16'sh7fff,  16'sh7fff,  15'd0,     15'd0,     1'b0, 1'b0, 16'sd0, 16'sd0},
    '{CMD_CANDIDATE, 16'sd100,   16'sd101,   15'd0,     15'd0,     1'b0, 1'b0, 16'sd0, 16'sd0},
    '{CMD_SPARE_LO,  16'sd5,     16'sd5,     15'd5,     15'd5,     1'b0, 1'b0, 16'sd0, 16'sd0},
    '{CMD_SPARE_HI,  16'shffff,  16'shffff,  15'h7fff,  15'h7fff,  1'b0, 1'b0, 16'sd0, 16'sd0},
    '{CMD_FINISH,    16'sd0,     16'sd0,     15'd0,     15'd0,     1'b1, 1'b1, 16'sd101, 16'sd100},
    '{CMD_FINISH,    16'sd0,     16'sd0,     15'd0,     15'd0,     1'b1, 1'b1, 16'sd101, 16'sd100},
    '{CMD_CLEAR,     16'sd0,     16'sd0,     15'd0,     15'd0,     1'b0, 1'b0, 16'sd0, 16'sd0},
    '{CMD_CANDIDATE, 16'shfffe,  16'shfffe,  15'd0,     15'd0,     1'b0, 1'b0, 16'sd0, 16'sd0},
    '{CMD_FINISH,    16'sd0,     16'sd0,     15'd0,     15'd0,     1'b1, 1'b1, -16'sd2, -16'sd2},
    '{CMD_START,     16'sh7fff,  16'sh8000,  15'd0,     15'd0,     1'b0, 1'b0, 16'sd0, 16'sd0},
    '{CMD_FINISH,    16'sd0,     16'sd0,     15'd0,     15'd0,     1'b1, 1'b0, 16'sd0, 16'sd0},
    '{CMD_CANDIDATE, 16'sh8000,  16'sh7fff,  15'd0,     15'd0,     1'b0, 1'b0, 16'sd0, 16'sd0},
    '{CMD_FINISH,    16'sd0,     16'sd0,     15'd0,     15'd0,     1'b1, 1'b1, 16'sh8000, 16'sh7fff}
  };

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic [2:0]                cmd;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic [SIZE_W-1:0]         box_width;
  logic [SIZE_W-1:0]         box_height;
  logic                      out_valid;
  logic                      out_stall;
  logic                      found;
  logic signed [COORD_W-1:0] best_x;
  logic signed [COORD_W-1:0] best_y;
  logic                      cfg_wr_en;
  logic [SIZE_W-1:0]         cfg_wr_data;

  nearest_point_with_exclusions u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .box_width   (box_width),
    .box_height  (box_height),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .best_x      (best_x),
    .best_y      (best_y),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // search state mirrored on the testbench side
  box_entry_t         box_tbl [BOX_DEPTH];
  point_t             rsv_tbl [RSV_DEPTH];
  int                 box_fill = 0;
  int                 rsv_fill = 0;
  logic signed [15:0] anchor_x = '0;
  logic signed [15:0] anchor_y = '0;
  longint             near_d2 = (longint'(1) << 34) - 1;
  logic signed [15:0] near_x = '0;
  logic signed [15:0] near_y = '0;
  logic               near_hit = 1'b0;
  logic [14:0]        radius_cfg = '0;

  nearest_result_t pending_results[$];
  int              errors = 0;
  int              items_sent = 0;
  bit              idle_on = 1'b1;
  bit              quiet = 1'b0;
  int              hold_asks = 0;

  function automatic longint sq_dist(input int ax, input int ay, input int bx, input int by);
    longint dx;
    longint dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return dx * dx + dy * dy;
  endfunction

  function automatic bit is_blocked(input int px, input int py);
    longint r2;
    r2 = longint'(radius_cfg) * longint'(radius_cfg);
    for (int i = 0; i < box_fill; i++) begin
      // half-open box: the far edges are outside
      if (int'(box_tbl[i].x) <= px && px < int'(box_tbl[i].x) + int'(box_tbl[i].w) &&
          int'(box_tbl[i].y) <= py && py < int'(box_tbl[i].y) + int'(box_tbl[i].h))
        return 1'b1;
    end
    for (int i = 0; i < rsv_fill; i++) begin
      if (sq_dist(px, py, rsv_tbl[i].x, rsv_tbl[i].y) <= r2)
        return 1'b1;
    end
    return 1'b0;
  endfunction

  // applies one accepted item, returns 1 when it yields a result
  function automatic bit step_nearest(input logic [2:0] op, input logic signed [15:0] px,
                                      input logic signed [15:0] py, input logic [14:0] bw,
                                      input logic [14:0] bh, output nearest_result_t outcome);
    longint d;
    outcome = '0;
    case (op)
      CMD_CLEAR: begin
        box_fill = 0;
        rsv_fill = 0;
      end
      CMD_ADD_BOX: begin
        if (box_fill < BOX_DEPTH) begin
          box_tbl[box_fill] = '{x: px, y: py, w: bw, h: bh};
          box_fill++;
        end
      end
      CMD_ADD_RES: begin
        if (rsv_fill < RSV_DEPTH) begin
          rsv_tbl[rsv_fill] = '{x: px, y: py};
          rsv_fill++;
        end
      end
      CMD_START: begin
        anchor_x = px;
        anchor_y = py;
        near_d2  = (longint'(1) << 34) - 1;
        near_x   = '0;
        near_y   = '0;
        near_hit = 1'b0;
      end
      CMD_CANDIDATE: begin
        if (!is_blocked(px, py)) begin
          d = sq_dist(px, py, anchor_x, anchor_y);
          // strict compare keeps the first of equal distances
          if (d < near_d2) begin
            near_d2  = d;
            near_x   = px;
            near_y   = py;
            near_hit = 1'b1;
          end
        end
      end
      CMD_FINISH: begin
        outcome.hit = near_hit;
        outcome.x   = near_hit ? near_x : '0;
        outcome.y   = near_hit ? near_y : '0;
      end
      default: ;
    endcase
    return op == CMD_FINISH;
  endfunction

  task automatic offer_item(input logic [2:0] op, input logic signed [15:0] px,
                            input logic signed [15:0] py, input logic [14:0] bw,
                            input logic [14:0] bh, output bit produced,
                            output nearest_result_t outcome);
    if (idle_on && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= op;
    coord_x    <= px;
    coord_y    <= py;
    box_width  <= bw;
    box_height <= bh;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    produced = step_nearest(op, px, py, bw, bh, outcome);
    items_sent++;
  endtask

  task automatic send_cmd(input logic [2:0] op, input logic signed [15:0] px,
                          input logic signed [15:0] py, input logic [14:0] bw,
                          input logic [14:0] bh);
    bit              produced;
    nearest_result_t outcome;
    offer_item(op, px, py, bw, bh, produced, outcome);
    if (produced) pending_results.push_back(outcome);
  endtask

  // hold the input until every finish has answered and the block has settled
  task automatic await_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_radius(input logic [14:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    radius_cfg = value;
  endtask

  function automatic logic signed [15:0] near_pt(input logic signed [15:0] c, input int spread);
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'(int'(c) + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic logic [14:0] box_dim(input int spread);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 15'($urandom);
      default: return 15'($urandom_range(1, spread));
    endcase
  endfunction

  // one search: optional noise, table setup, start, candidates, finish
  task automatic run_search_round(input int round);
    int                 nbox;
    int                 nrsv;
    int                 ncand;
    int                 spread;
    bit                 press;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [14:0]        rad;
    await_drain();
    case (round)
      0:       rad = 15'h7fff;
      1:       rad = '0;
      default: rad = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 96));
    endcase
    write_radius(rad);
    quiet   = (items_sent >= NUM_DIRECTED + RANDOM_ITEMS - 80);
    idle_on = ($urandom_range(0, 3) != 0);
    press   = (round == 2);
    spread  = ($urandom_range(0, 3) == 0) ? 4096 : $urandom_range(16, 512);
    cx      = 16'($urandom);
    cy      = 16'($urandom);
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(2, 6))
        send_cmd(3'($urandom), 16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom));
    end
    if ($urandom_range(0, 7) != 0)
      send_cmd(CMD_CLEAR, 16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom));
    nbox = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 5);
    repeat (nbox)
      send_cmd(CMD_ADD_BOX, near_pt(cx, spread), near_pt(cy, spread),
               box_dim(spread), box_dim(spread));
    nrsv = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 5);
    repeat (nrsv)
      send_cmd(CMD_ADD_RES, near_pt(cx, spread), near_pt(cy, spread),
               15'($urandom), 15'($urandom));
    if ($urandom_range(0, 9) != 0)
      send_cmd(CMD_START, near_pt(cx, spread), near_pt(cy, spread),
               15'($urandom), 15'($urandom));
    // long receiver hold while finishes keep coming, so the input backs up
    if (press) hold_asks++;
    ncand = press ? 8 : $urandom_range(1, 12);
    repeat (ncand) begin
      send_cmd(CMD_CANDIDATE, near_pt(cx, spread), near_pt(cy, spread),
               15'($urandom), 15'($urandom));
      if (press) send_cmd(CMD_FINISH, 16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom));
    end
    send_cmd(CMD_FINISH, 16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom));
    if ($urandom_range(0, 3) == 0)
      send_cmd(CMD_FINISH, 16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom));
  endtask

  task automatic check_result();
    nearest_result_t want;
    if (pending_results.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: found=%0d x=%0d y=%0d", found, best_x, best_y);
    end else begin
      want = pending_results.pop_front();
      if (found !== want.hit || best_x !== want.x || best_y !== want.y) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: expected found=%0d x=%0d y=%0d, got found=%0d x=%0d y=%0d",
                   want.hit, want.x, want.y, found, best_x, best_y);
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stall bursts plus one long hold on request
  initial begin
    int hold_left;
    int burst_left;
    int hold_seen;
    hold_left  = 0;
    burst_left = 0;
    hold_seen  = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) check_result();
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end else if (burst_left > 0) begin
        burst_left--;
      end else if (idle_on && !quiet && $urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(1, 6);
      end
      out_stall <= (hold_left > 0) || (burst_left > 0);
    end
  end

  initial begin
    bit              produced;
    nearest_result_t outcome;
    int              round;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    cmd         <= CMD_CLEAR;
    coord_x     <= '0;
    coord_y     <= '0;
    box_width   <= '0;
    box_height  <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      offer_item(DIRECTED[i].op, DIRECTED[i].px, DIRECTED[i].py, DIRECTED[i].bw,
                 DIRECTED[i].bh, produced, outcome);
      if (DIRECTED[i].typed)
        pending_results.push_back('{hit: DIRECTED[i].t_hit, x: DIRECTED[i].t_x,
                                    y: DIRECTED[i].t_y});
      else if (produced)
        pending_results.push_back(outcome);
    end

    round = 0;
    while (items_sent < NUM_DIRECTED + RANDOM_ITEMS) begin
      run_search_round(round);
      round++;
    end

    await_drain();
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
